@@ hw/rtl/bsht_pkg.sv @@
package bsht_pkg;

    // operation codes
    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_INSERT  = 2'd1;
    localparam logic [1:0] OP_NEAREST = 2'd2;
    localparam logic [1:0] OP_WINDOW  = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_NONE    = 3'd3;
    localparam logic [2:0] ST_LIMIT   = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_ZONE_START  = 3'd0;
    localparam logic [2:0] CFG_ZONE_LENGTH = 3'd1;
    localparam logic [2:0] CFG_ROW_SCALE   = 3'd2;
    localparam logic [2:0] CFG_ROAD_Y      = 3'd3;
    localparam logic [2:0] CFG_ROAD_Z      = 3'd4;

    // rows checked by a nearest query
    localparam int NEIGHBOUR_ROWS = 3;

    typedef struct packed {
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic        [19:0] ident;
    } entry_t;

    // |a - b|, exact
    function automatic logic [18:0] abs_diff(input logic signed [17:0] a,
                                             input logic signed [17:0] b);
        logic [18:0] d;
        d = {a[17], a} - {b[17], b};
        return d[18] ? (~d + 19'd1) : d;
    endfunction

endpackage

@@ hw/rtl/bsht_ram.sv @@
module bsht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/bsht_row_map.sv @@
module bsht_row_map #(
    parameter int ROWS = 16
) (
    input  logic                    aclk,
    input  logic [16:0]             offset,
    input  logic [23:0]             scale,
    output logic [$clog2(ROWS)-1:0] row
);

    localparam int RW = $clog2(ROWS);

    // offset * scale, 16 fraction bits
    logic [40:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= offset * scale;
    end

    // saturate to the top row
    assign row = (prod_reg[40:16] > 25'(ROWS - 1)) ? RW'(ROWS - 1) : prod_reg[16 +: RW];

endmodule

@@ hw/rtl/binned_sorted_hit_table.sv @@
// Channel  Direction  Handshake               Payload
// s_       in         s_valid / s_ready       operation, pos_y, pos_z, half_width_y/z,
//                                             hit_id, used_flag, max_matches
// m_       out        m_valid / m_ready       status, slot, found_id, last
// cfg_     in         cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// One input transaction at a time. Each entry looked at takes a read of the
// entry RAM and a compare. Clear only resets the row starts and count; insert
// scans the entries of its row at or below y, then shifts later entries up; nearest
// scans each checked row around the centre; window scans each row and its entries.
// Reset (aresetn low, synchronous) empties the table and loads default config.
// A stalled result channel holds the sequencer at its next result only.
module binned_sorted_hit_table #(
    parameter int CAPACITY = 64,
    parameter int ROWS     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [17:0] s_pos_y,
    input  logic signed [17:0] s_pos_z,
    input  logic [16:0]        s_half_width_y,
    input  logic [16:0]        s_half_width_z,
    input  logic [19:0]        s_hit_id,
    input  logic               s_used_flag,
    input  logic [6:0]         s_max_matches,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [5:0]         m_slot,
    output logic [19:0]        m_found_id,
    output logic               m_last,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    import bsht_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = $clog2(ROWS);

    typedef enum logic [22:0] {
        S_IDLE    = 23'd1,
        S_DECODE  = 23'd2,
        S_MUL     = 23'd4,
        S_ROWCALC = 23'd8,
        S_RB_LO   = 23'd16,
        S_RB_HI   = 23'd32,
        S_INS_RD  = 23'd64,
        S_INS_EV  = 23'd128,
        S_SH_RD   = 23'd256,
        S_SH_WR   = 23'd512,
        S_INS_WR  = 23'd1024,
        S_NR_ROW  = 23'd2048,
        S_NR_RD   = 23'd4096,
        S_NR_EV   = 23'd8192,
        S_NR_P    = 23'd16384,
        S_NR_PEV  = 23'd32768,
        S_NR_QEV  = 23'd65536,
        S_NR_CHK  = 23'd131072,
        S_NR_DONE = 23'd262144,
        S_W_RD    = 23'd524288,
        S_W_EV    = 23'd1048576,
        S_W_END   = 23'd2097152,
        S_EMIT    = 23'd4194304
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [17:0] zs_reg;
    logic [16:0]        zlen_reg;
    logic [23:0]        scale_reg;
    logic [16:0]        road_y_reg;
    logic [16:0]        road_z_reg;

    // table bookkeeping
    logic [CW-1:0] row_start_reg [ROWS];
    logic [CW-1:0] count_reg;

    // latched transaction
    logic [1:0]         op_reg;
    logic signed [17:0] y_reg;
    logic signed [17:0] z_reg;
    logic [16:0]        hy_reg;
    logic [16:0]        hz_reg;
    logic [19:0]        id_reg;
    logic               used_reg;
    logic [6:0]         limit_reg;

    // sequencer working registers
    logic [16:0]        mul_d_reg;
    logic               phase_reg;
    logic [RW-1:0]      cur_row_reg;
    logic [RW-1:0]      rhi_reg;
    logic [RW-1:0]      centre_reg;
    logic [1:0]         k_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      scan_reg;
    logic [AW-1:0]      pos_reg;
    logic [AW-1:0]      sh_reg;
    logic [AW-1:0]      p_reg;
    entry_t             cand_reg;
    logic [AW-1:0]      cand_slot_reg;
    logic [18:0]        best_reg;
    logic               found_reg;
    logic [AW-1:0]      best_slot_reg;
    logic [19:0]        best_id_reg;
    logic signed [19:0] zlo_reg;
    logic signed [19:0] zhi_reg;
    logic               full_reg;
    logic [6:0]         n_reg;
    logic               hit_reg;
    logic               pend_v_reg;
    logic [AW-1:0]      pend_slot_reg;
    logic [19:0]        pend_id_reg;

    // single result waiting to be pushed
    logic [2:0]         res_status_reg;
    logic [AW-1:0]      res_slot_reg;
    logic [19:0]        res_id_reg;

    // output register
    logic               m_valid_reg;
    logic [2:0]         m_status_reg;
    logic [5:0]         m_slot_reg;
    logic [19:0]        m_id_reg;
    logic               m_last_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // entry RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rbits;
    entry_t        rd;

    assign rd = entry_t'(ram_rbits);

    bsht_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CAPACITY)
    ) u_entry_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rbits)
    );

    // z offset to row
    logic [RW-1:0] map_row;

    bsht_row_map #(
        .ROWS(ROWS)
    ) u_row_map (
        .aclk  (aclk),
        .offset(mul_d_reg),
        .scale (scale_reg),
        .row   (map_row)
    );

    // zone arithmetic, 20-bit signed
    logic signed [19:0] zs20, zend20, z20, y20, zlo0, zhi0, zlo_c, zhi_c;
    logic signed [19:0] ylo20, yhi20, ey20, ez20;
    logic [19:0]        d_z, d_lo, d_hi;
    logic [AW:0]        p_next;

    always_comb begin
        zs20   = {{2{zs_reg[17]}}, zs_reg};
        zend20 = zs20 + {3'b000, zlen_reg};
        z20    = {{2{z_reg[17]}}, z_reg};
        y20    = {{2{y_reg[17]}}, y_reg};
        zlo0   = z20 - {3'b000, hz_reg};
        zhi0   = z20 + {3'b000, hz_reg};
        zlo_c  = (zlo0 < zs20) ? zs20 : zlo0;
        zhi_c  = (zhi0 > zend20) ? zend20 : zhi0;
        ylo20  = y20 - {3'b000, hy_reg};
        yhi20  = y20 + {3'b000, hy_reg};
        ey20   = {{2{rd.y[17]}}, rd.y};
        ez20   = {{2{rd.z[17]}}, rd.z};
        d_z    = z20 - zs20;
        d_lo   = zlo_c - zs20;
        d_hi   = zhi_reg - zs20;
        p_next = {1'b0, p_reg} + 1'b1;
    end

    // window entry tests, and whether the output register loads this cycle
    logic w_stop, w_skip, m_load;
    assign w_stop = ey20 > yhi20;
    assign w_skip = ey20 < ylo20 || ez20 < zlo_reg || ez20 > zhi_reg;
    assign m_load = out_free && ((state_reg == S_EMIT)
                    || (state_reg == S_W_EV && !w_stop && !w_skip && pend_v_reg));

    // row_start read port, one index a cycle
    logic [RW-1:0] rs_idx;
    logic [CW-1:0] rs_rd;
    logic [CW-1:0] hi_c;

    always_comb begin
        rs_idx = cur_row_reg;
        if (state_reg == S_RB_HI && cur_row_reg != RW'(ROWS - 1)) begin
            rs_idx = cur_row_reg + 1'b1;
        end
        rs_rd = row_start_reg[rs_idx];
        if (cur_row_reg == RW'(ROWS - 1)) begin
            hi_c = count_reg;
        end else begin
            hi_c = (rs_rd > count_reg) ? count_reg : rs_rd;
        end
    end

    // RAM port control
    always_comb begin
        ram_re    = 1'b0;
        ram_raddr = scan_reg[AW-1:0];
        ram_we    = 1'b0;
        ram_waddr = sh_reg;
        ram_wdata = rd;
        case (state_reg)
            S_INS_RD, S_NR_RD: begin
                ram_re = scan_reg < hi_reg;
            end
            S_W_RD: begin
                ram_re = (scan_reg < hi_reg) && (n_reg < limit_reg);
            end
            S_SH_RD: begin
                ram_re    = sh_reg > pos_reg;
                ram_raddr = sh_reg - 1'b1;
            end
            S_NR_P: begin
                ram_re    = 1'b1;
                ram_raddr = p_reg;
            end
            S_NR_PEV: begin
                ram_re    = CW'(p_next) < hi_reg;
                ram_raddr = p_next[AW-1:0];
            end
            S_SH_WR: begin
                ram_we = 1'b1;
            end
            S_INS_WR: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = '{y: y_reg, z: z_reg, ident: id_reg};
            end
            default: begin
            end
        endcase
    end

    // nearest candidate check
    logic [18:0] nr_dy, nr_dz, nr_dist, q_dy;
    always_comb begin
        nr_dy   = abs_diff(y_reg, cand_reg.y);
        nr_dz   = abs_diff(z_reg, cand_reg.z);
        nr_dist = (nr_dy > nr_dz) ? nr_dy : nr_dz;
        q_dy    = abs_diff(y_reg, rd.y);
    end

    logic [RW:0] nr_ck;
    assign nr_ck = {1'b0, centre_reg} + {{(RW - 1){1'b0}}, k_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            zs_reg      <= '0;
            zlen_reg    <= 17'd4096;
            scale_reg   <= 24'd256;
            road_y_reg  <= 17'd256;
            road_z_reg  <= 17'd2048;
            count_reg   <= '0;
            for (int i = 0; i < ROWS; i++) begin
                row_start_reg[i] <= '0;
            end
            m_valid_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_ZONE_START:  zs_reg     <= cfg_data[17:0];
                    CFG_ZONE_LENGTH: zlen_reg   <= cfg_data[16:0];
                    CFG_ROW_SCALE:   scale_reg  <= cfg_data;
                    CFG_ROAD_Y:      road_y_reg <= cfg_data[16:0];
                    CFG_ROAD_Z:      road_z_reg <= cfg_data[16:0];
                    default: begin
                    end
                endcase
            end

            if (m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg     <= s_operation;
                        y_reg      <= s_pos_y;
                        z_reg      <= s_pos_z;
                        hy_reg     <= s_half_width_y;
                        hz_reg     <= s_half_width_z;
                        id_reg     <= s_hit_id;
                        used_reg   <= s_used_flag;
                        limit_reg  <= s_max_matches;
                        n_reg      <= '0;
                        hit_reg    <= 1'b0;
                        pend_v_reg <= 1'b0;
                        phase_reg  <= 1'b0;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    res_slot_reg <= '0;
                    res_id_reg   <= '0;
                    case (op_reg)
                        OP_CLEAR: begin
                            count_reg <= '0;
                            for (int i = 0; i < ROWS; i++) begin
                                row_start_reg[i] <= '0;
                            end
                            res_status_reg <= ST_OK;
                            state_reg      <= S_EMIT;
                        end
                        OP_INSERT: begin
                            if (used_reg || z20 < zs20 || z20 > zend20) begin
                                res_status_reg <= ST_DROPPED;
                                state_reg      <= S_EMIT;
                            end else if (count_reg >= CW'(CAPACITY)) begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_EMIT;
                            end else begin
                                mul_d_reg <= d_z[16:0];
                                state_reg <= S_MUL;
                            end
                        end
                        OP_NEAREST: begin
                            k_reg     <= '0;
                            best_reg  <= {2'b00, road_z_reg};
                            found_reg <= 1'b0;
                            if (z20 < zs20) begin
                                centre_reg <= '0;
                                state_reg  <= S_NR_ROW;
                            end else if (z20 > zend20) begin
                                centre_reg <= RW'(ROWS - 1);
                                state_reg  <= S_NR_ROW;
                            end else begin
                                mul_d_reg <= d_z[16:0];
                                state_reg <= S_MUL;
                            end
                        end
                        default: begin
                            zlo_reg  <= zlo_c;
                            zhi_reg  <= zhi_c;
                            full_reg <= zhi0 > zend20;
                            if (zlo_c > zhi_c) begin
                                state_reg <= S_W_END;
                            end else begin
                                mul_d_reg <= d_lo[16:0];
                                state_reg <= S_MUL;
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    state_reg <= S_ROWCALC;
                end
                S_ROWCALC: begin
                    case (op_reg)
                        OP_INSERT: begin
                            cur_row_reg <= map_row;
                            state_reg   <= S_RB_LO;
                        end
                        OP_NEAREST: begin
                            centre_reg <= map_row;
                            state_reg  <= S_NR_ROW;
                        end
                        default: begin
                            if (!phase_reg) begin
                                cur_row_reg <= map_row;
                                if (full_reg) begin
                                    rhi_reg   <= RW'(ROWS - 1);
                                    state_reg <= S_RB_LO;
                                end else begin
                                    mul_d_reg <= d_hi[16:0];
                                    phase_reg <= 1'b1;
                                    state_reg <= S_MUL;
                                end
                            end else begin
                                rhi_reg   <= map_row;
                                state_reg <= S_RB_LO;
                            end
                        end
                    endcase
                end
                S_RB_LO: begin
                    lo_reg    <= rs_rd;
                    state_reg <= S_RB_HI;
                end
                S_RB_HI: begin
                    hi_reg   <= hi_c;
                    scan_reg <= lo_reg;
                    p_reg    <= lo_reg[AW-1:0];
                    case (op_reg)
                        OP_INSERT: state_reg <= S_INS_RD;
                        OP_NEAREST: begin
                            if (lo_reg >= hi_c) begin
                                k_reg     <= k_reg + 1'b1;
                                state_reg <= S_NR_ROW;
                            end else begin
                                state_reg <= S_NR_RD;
                            end
                        end
                        default: state_reg <= S_W_RD;
                    endcase
                end

                // insert: find position, shift up, write
                S_INS_RD: begin
                    if (scan_reg < hi_reg) begin
                        state_reg <= S_INS_EV;
                    end else begin
                        pos_reg   <= scan_reg[AW-1:0];
                        sh_reg    <= count_reg[AW-1:0];
                        state_reg <= S_SH_RD;
                    end
                end
                S_INS_EV: begin
                    if (rd.y <= y_reg) begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_INS_RD;
                    end else begin
                        pos_reg   <= scan_reg[AW-1:0];
                        sh_reg    <= count_reg[AW-1:0];
                        state_reg <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    state_reg <= (sh_reg > pos_reg) ? S_SH_WR : S_INS_WR;
                end
                S_SH_WR: begin
                    sh_reg    <= sh_reg - 1'b1;
                    state_reg <= S_SH_RD;
                end
                S_INS_WR: begin
                    for (int i = 0; i < ROWS; i++) begin
                        if (i > int'(cur_row_reg)) begin
                            row_start_reg[i] <= row_start_reg[i] + 1'b1;
                        end
                    end
                    count_reg      <= count_reg + 1'b1;
                    res_status_reg <= ST_OK;
                    res_slot_reg   <= pos_reg;
                    res_id_reg     <= id_reg;
                    state_reg      <= S_EMIT;
                end

                // nearest: three rows around the centre
                S_NR_ROW: begin
                    if (k_reg == 2'(NEIGHBOUR_ROWS)) begin
                        state_reg <= S_NR_DONE;
                    end else if (nr_ck == '0) begin
                        k_reg <= k_reg + 1'b1;
                    end else if (nr_ck - 1'b1 > (RW + 1)'(ROWS - 1)) begin
                        state_reg <= S_NR_DONE;
                    end else begin
                        cur_row_reg <= RW'(nr_ck - 1'b1);
                        state_reg   <= S_RB_LO;
                    end
                end
                S_NR_RD: begin
                    state_reg <= (scan_reg < hi_reg) ? S_NR_EV : S_NR_P;
                end
                S_NR_EV: begin
                    if (rd.y <= y_reg) begin
                        p_reg <= scan_reg[AW-1:0];
                    end
                    scan_reg  <= scan_reg + 1'b1;
                    state_reg <= S_NR_RD;
                end
                S_NR_P: begin
                    state_reg <= S_NR_PEV;
                end
                S_NR_PEV: begin
                    cand_reg      <= rd;
                    cand_slot_reg <= p_reg;
                    state_reg     <= (CW'(p_next) < hi_reg) ? S_NR_QEV : S_NR_CHK;
                end
                S_NR_QEV: begin
                    if (q_dy < nr_dy) begin
                        cand_reg      <= rd;
                        cand_slot_reg <= p_next[AW-1:0];
                    end
                    state_reg <= S_NR_CHK;
                end
                S_NR_CHK: begin
                    if (nr_dy <= {2'b00, road_y_reg} && nr_dz <= {2'b00, road_z_reg}
                            && nr_dist < best_reg) begin
                        best_reg      <= nr_dist;
                        found_reg     <= 1'b1;
                        best_slot_reg <= cand_slot_reg;
                        best_id_reg   <= cand_reg.ident;
                    end
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= S_NR_ROW;
                end
                S_NR_DONE: begin
                    if (found_reg) begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= best_slot_reg;
                        res_id_reg     <= best_id_reg;
                    end else begin
                        res_status_reg <= ST_NONE;
                        res_slot_reg   <= '0;
                        res_id_reg     <= '0;
                    end
                    state_reg <= S_EMIT;
                end

                // window: rows rlo..rhi, one match held back for the final status
                S_W_RD: begin
                    if (scan_reg < hi_reg) begin
                        if (n_reg >= limit_reg) begin
                            hit_reg   <= 1'b1;
                            state_reg <= S_W_END;
                        end else begin
                            state_reg <= S_W_EV;
                        end
                    end else if (cur_row_reg == rhi_reg) begin
                        state_reg <= S_W_END;
                    end else begin
                        cur_row_reg <= cur_row_reg + 1'b1;
                        state_reg   <= S_RB_LO;
                    end
                end
                S_W_EV: begin
                    if (w_stop) begin
                        if (cur_row_reg == rhi_reg) begin
                            state_reg <= S_W_END;
                        end else begin
                            cur_row_reg <= cur_row_reg + 1'b1;
                            state_reg   <= S_RB_LO;
                        end
                    end else if (w_skip) begin
                        scan_reg  <= scan_reg + 1'b1;
                        state_reg <= S_W_RD;
                    end else if (!pend_v_reg || out_free) begin
                        if (pend_v_reg) begin
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= ST_OK;
                            m_slot_reg   <= 6'(pend_slot_reg);
                            m_id_reg     <= pend_id_reg;
                            m_last_reg   <= 1'b0;
                        end
                        pend_v_reg    <= 1'b1;
                        pend_slot_reg <= scan_reg[AW-1:0];
                        pend_id_reg   <= rd.ident;
                        n_reg         <= n_reg + 1'b1;
                        scan_reg      <= scan_reg + 1'b1;
                        state_reg     <= S_W_RD;
                    end
                end
                S_W_END: begin
                    if (pend_v_reg) begin
                        res_status_reg <= hit_reg ? ST_LIMIT : ST_OK;
                        res_slot_reg   <= pend_slot_reg;
                        res_id_reg     <= pend_id_reg;
                    end else begin
                        res_status_reg <= hit_reg ? ST_LIMIT : ST_NONE;
                        res_slot_reg   <= '0;
                        res_id_reg     <= '0;
                    end
                    state_reg <= S_EMIT;
                end

                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_slot_reg   <= 6'(res_slot_reg);
                        m_id_reg     <= res_id_reg;
                        m_last_reg   <= 1'b1;
                        pend_v_reg   <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_slot     = m_slot_reg;
    assign m_found_id = m_id_reg;
    assign m_last     = m_last_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("hit count beyond capacity");

    a_rows_in_count: assert property (@(posedge aclk) disable iff (!aresetn)
        row_start_reg[ROWS-1] <= count_reg)
        else $error("top row starts beyond hit count");

    a_pend_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_v_reg |-> n_reg != '0)
        else $error("held window match not counted");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_WR) |-> (count_reg < CW'(CAPACITY)) && ({1'b0, pos_reg} <= count_reg))
        else $error("insert position outside table");

endmodule
